// File: hdl/urss_pkg.sv
// package: widths, constants and register codes of the ultrasonic ranger with servo sweep
`default_nettype none

package urss_pkg;

  localparam int TICK_WIDTH   = 16;
  localparam int PERIOD_W     = 16;
  localparam int SERVO_W      = 12;
  localparam int DIST_W       = 24;
  localparam int APB_ADDR_W   = 4;
  localparam int APB_DATA_W   = 32;
  localparam int REG_IDX_W    = 2;

  localparam logic [REG_IDX_W-1:0] REG_TRIGGER_PERIOD = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SERVO_STEP     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SERVO_LIMIT    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SERVO_RESTART  = 2'd3;

  localparam logic [PERIOD_W-1:0] TRIGGER_PERIOD_RST = 16'd6800;
  localparam logic [SERVO_W-1:0]  SERVO_STEP_RST     = 12'd105;
  localparam logic [SERVO_W-1:0]  SERVO_LIMIT_RST    = 12'd2400;
  localparam logic [SERVO_W-1:0]  SERVO_RESTART_RST  = 12'd510;
  localparam logic [SERVO_W-1:0]  SERVO_POS_RST      = 12'd405;

  // distance = (256*(t*(t+16700) + 86490) + 50000) / 100000
  localparam int RANGE_C1    = 16700;
  localparam int RANGE_C0    = 86490;
  localparam int RANGE_ROUND = 50000;
  localparam int RANGE_DIV   = 100000;
  localparam int FRAC_SHIFT  = 8;
  localparam logic [63:0] DIV_LIMIT = 64'(RANGE_DIV) << DIST_W;

  // low five bits drop out of the divide; the rest divides by 3125 via a reciprocal
  localparam int DROP_BITS   = 5;
  localparam int SCALED_W    = 36;
  localparam int RECIP_SHIFT = 46;
  localparam logic [SCALED_W-1:0] RECIP_M = 36'd22517998137;

  typedef struct packed {
    logic             done;
    logic [DIST_W-1:0] distance;
  } dist_status_t;

endpackage

`default_nettype wire

// File: hdl/urss_ifs.sv
// interfaces: event channel and result channel
`default_nettype none

interface urss_evt_if;
  logic valid;
  logic ready;
  logic op;
  logic echo_level;
  modport source (output valid, output op, output echo_level, input ready);
  modport sink (input valid, input op, input echo_level, output ready);
endinterface

interface urss_res_if;
  logic                        valid;
  logic                        ready;
  logic                        trigger_out;
  logic [urss_pkg::DIST_W-1:0]  distance_fixed;
  logic                        distance_valid;
  logic [urss_pkg::SERVO_W-1:0] servo_width;
  modport source (output valid, output trigger_out, output distance_fixed,
                  output distance_valid, output servo_width, input ready);
  modport sink (input valid, input trigger_out, input distance_fixed,
                input distance_valid, input servo_width, output ready);
endinterface

`default_nettype wire

// File: hdl/ultrasonic_ranger_servo_sweep.sv
// top level: trigger timing, echo timing, servo sweep, apb registers and result register
//
//  channel | role   | moves
//  evt     | sink   | op, echo_level
//  res     | source | trigger_out, distance_fixed, distance_valid, servo_width
//  apb     | slave  | four config registers at 0x0, 0x4, 0x8, 0xc
//
//  a tick or rising edge has its result registered at the accepting edge
//  a falling edge runs the distance unit: multiply, scale, range check, 4 partial products
//  a saturated distance skips the partial products
//  rst is synchronous and restores register and state reset values
//  evt.ready is low while the distance unit runs and while an unread result blocks the output
`default_nettype none

module ultrasonic_ranger_servo_sweep #(
  parameter int TICK_WIDTH = urss_pkg::TICK_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  urss_evt_if.sink                               evt,
  urss_res_if.source                             res,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [urss_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [urss_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [urss_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic [urss_pkg::PERIOD_W-1:0] trigger_period;
  logic [urss_pkg::SERVO_W-1:0]  servo_step;
  logic [urss_pkg::SERVO_W-1:0]  servo_limit;
  logic [urss_pkg::SERVO_W-1:0]  servo_restart;

  logic                          state;
  logic [urss_pkg::PERIOD_W-1:0] trigger_count;
  logic [urss_pkg::PERIOD_W-1:0] trigger_count_next;
  logic                          trigger_level;
  logic                          trigger_level_next;
  logic                          measuring;
  logic [TICK_WIDTH-1:0]         echo_ticks;
  logic [urss_pkg::DIST_W-1:0]   last_distance;
  logic [urss_pkg::SERVO_W-1:0]  servo_position;
  logic [urss_pkg::SERVO_W-1:0]  servo_position_next;
  logic [urss_pkg::SERVO_W:0]    servo_sum;

  logic                          out_valid;
  logic                          out_trigger;
  logic [urss_pkg::DIST_W-1:0]   out_distance;
  logic                          out_dist_valid;
  logic [urss_pkg::SERVO_W-1:0]  out_servo;

  logic                          accept;
  logic                          is_tick;
  logic                          is_fall;
  logic                          cfg_write;
  logic [urss_pkg::REG_IDX_W-1:0] reg_idx;
  urss_pkg::dist_status_t        dist_st;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[urss_pkg::REG_IDX_W+1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      urss_pkg::REG_TRIGGER_PERIOD: prdata = 32'(trigger_period);
      urss_pkg::REG_SERVO_STEP:     prdata = 32'(servo_step);
      urss_pkg::REG_SERVO_LIMIT:    prdata = 32'(servo_limit);
      urss_pkg::REG_SERVO_RESTART:  prdata = 32'(servo_restart);
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_period <= urss_pkg::TRIGGER_PERIOD_RST;
      servo_step     <= urss_pkg::SERVO_STEP_RST;
      servo_limit    <= urss_pkg::SERVO_LIMIT_RST;
      servo_restart  <= urss_pkg::SERVO_RESTART_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        urss_pkg::REG_TRIGGER_PERIOD: trigger_period <= pwdata[urss_pkg::PERIOD_W-1:0];
        urss_pkg::REG_SERVO_STEP:     servo_step     <= pwdata[urss_pkg::SERVO_W-1:0];
        urss_pkg::REG_SERVO_LIMIT:    servo_limit    <= pwdata[urss_pkg::SERVO_W-1:0];
        urss_pkg::REG_SERVO_RESTART:  servo_restart  <= pwdata[urss_pkg::SERVO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign evt.ready = (state == ST_IDLE) && (!out_valid || res.ready);
  assign accept    = evt.valid && evt.ready;
  assign is_tick   = !evt.op;
  assign is_fall   = evt.op && !evt.echo_level;

  // idle trigger timing
  always_comb begin
    trigger_level_next = trigger_level;
    trigger_count_next = trigger_count;
    if (is_tick && !measuring) begin
      if (trigger_count == '0) begin
        trigger_level_next = 1'b0;
      end
      trigger_count_next = trigger_count + 1'b1;
      if (trigger_count_next == trigger_period) begin
        trigger_level_next = 1'b1;
        trigger_count_next = '0;
      end
    end
  end

  // servo sweep step
  always_comb begin
    servo_sum = {1'b0, servo_position} + {1'b0, servo_step};
    if (servo_sum > {1'b0, servo_limit}) begin
      servo_position_next = servo_restart;
    end else begin
      servo_position_next = servo_sum[urss_pkg::SERVO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      trigger_count  <= '0;
      trigger_level  <= 1'b0;
      measuring      <= 1'b0;
      echo_ticks     <= '0;
      last_distance  <= '0;
      servo_position <= urss_pkg::SERVO_POS_RST;
    end else begin
      if (accept) begin
        trigger_count <= trigger_count_next;
        trigger_level <= trigger_level_next;
        if (is_tick) begin
          if (measuring && (echo_ticks != '1)) begin
            echo_ticks <= echo_ticks + 1'b1;
          end
        end else if (evt.echo_level) begin
          echo_ticks <= '0;
          measuring  <= 1'b1;
        end else begin
          measuring      <= 1'b0;
          servo_position <= servo_position_next;
          state          <= ST_BUSY;
        end
      end
      if (dist_st.done) begin
        last_distance <= dist_st.distance;
        state         <= ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && !is_fall) begin
      out_valid <= 1'b1;
    end else if (dist_st.done) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_fall) begin
      out_trigger    <= trigger_level_next;
      out_distance   <= last_distance;
      out_dist_valid <= 1'b0;
      out_servo      <= servo_position;
    end else if (dist_st.done) begin
      out_trigger    <= trigger_level;
      out_distance   <= dist_st.distance;
      out_dist_valid <= 1'b1;
      out_servo      <= servo_position;
    end
  end

  assign res.valid          = out_valid;
  assign res.trigger_out    = out_trigger;
  assign res.distance_fixed = out_distance;
  assign res.distance_valid = out_dist_valid;
  assign res.servo_width    = out_servo;

  urss_dist_unit #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_dist (
    .clk    (clk),
    .rst    (rst),
    .start  (accept && is_fall),
    .ticks  (echo_ticks),
    .status (dist_st)
  );

  a_fall_starts_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && is_fall) |=> (state == ST_BUSY))
    else $error("falling edge did not start the distance unit");

  a_done_only_busy: assert property (@(posedge clk) disable iff (rst)
    dist_st.done |-> (state == ST_BUSY))
    else $error("distance result without a pending measurement");

  a_busy_output_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BUSY) |-> !out_valid)
    else $error("result register occupied while distance is computed");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BUSY) |-> !accept)
    else $error("item taken while distance is computed");

endmodule

`default_nettype wire

// File: hdl/urss_dist_unit.sv
// distance unit: one multiply, then a reciprocal multiply on one shared 18x18 multiplier
`default_nettype none

module urss_dist_unit #(
  parameter int TICK_WIDTH = urss_pkg::TICK_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [TICK_WIDTH-1:0] ticks,
  output urss_pkg::dist_status_t     status
);

  localparam int AW  = ((TICK_WIDTH > 15) ? TICK_WIDTH : 15) + 1;
  localparam int PW  = TICK_WIDTH + AW;
  localparam int YW  = urss_pkg::SCALED_W;
  localparam int LW  = YW + urss_pkg::DROP_BITS;
  localparam int XW  = ((PW + 10) > LW) ? (PW + 10) : LW;
  localparam int HW  = YW / 2;
  localparam int MW  = 2 * HW;
  localparam int CW  = 2 * YW;
  localparam int QW  = urss_pkg::DIST_W;

  localparam logic [YW-1:0] RECIP = urss_pkg::RECIP_M;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_SCALE = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_RECIP = 3'd4;

  logic [2:0]            state;
  logic [TICK_WIDTH-1:0] t_reg;
  logic [PW-1:0]         prod;
  logic [XW-1:0]         xval;
  logic [YW-1:0]         yval;
  logic [CW-1:0]         acc;
  logic [CW-1:0]         acc_sum;
  logic [1:0]            step;
  logic [HW-1:0]         mul_a;
  logic [HW-1:0]         mul_b;
  logic [MW-1:0]         part;
  logic [5:0]            part_shift;
  logic [QW-1:0]         quo;
  logic                  done;

  // one partial product a cycle
  always_comb begin
    case (step)
      2'd0: begin
        mul_a      = yval[HW-1:0];
        mul_b      = RECIP[HW-1:0];
        part_shift = 6'd0;
      end
      2'd1: begin
        mul_a      = yval[HW-1:0];
        mul_b      = RECIP[YW-1:HW];
        part_shift = 6'(HW);
      end
      2'd2: begin
        mul_a      = yval[YW-1:HW];
        mul_b      = RECIP[HW-1:0];
        part_shift = 6'(HW);
      end
      default: begin
        mul_a      = yval[YW-1:HW];
        mul_b      = RECIP[YW-1:HW];
        part_shift = 6'(2 * HW);
      end
    endcase
  end

  assign part    = MW'(mul_a) * MW'(mul_b);
  assign acc_sum = acc + (CW'(part) << part_shift);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            t_reg <= ticks;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= PW'(t_reg) * PW'(AW'(t_reg) + AW'(urss_pkg::RANGE_C1));
          state <= S_SCALE;
        end
        S_SCALE: begin
          xval  <= ((XW'(prod) + XW'(urss_pkg::RANGE_C0)) << urss_pkg::FRAC_SHIFT)
                   + XW'(urss_pkg::RANGE_ROUND);
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (xval >= XW'(urss_pkg::DIV_LIMIT)) begin
            quo   <= '1;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            yval  <= xval[urss_pkg::DROP_BITS +: YW];
            acc   <= '0;
            step  <= '0;
            state <= S_RECIP;
          end
        end
        S_RECIP: begin
          acc  <= acc_sum;
          step <= step + 1'b1;
          if (step == 2'd3) begin
            quo   <= acc_sum[urss_pkg::RECIP_SHIFT +: QW];
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign status.done     = done;
  assign status.distance = quo;

endmodule

`default_nettype wire

// File: test/ultrasonic_ranger_servo_sweep_test.sv
// testbench: drives ticks, echo edges and register writes into the ranger and checks every result
`default_nettype none

module ultrasonic_ranger_servo_sweep_test;

  localparam logic EV_TICK = 1'b0;
  localparam logic EV_EDGE = 1'b1;
  localparam logic LVL_FALL = 1'b0;
  localparam logic LVL_RISE = 1'b1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS = 170;
  localparam int RANDOM_PHASES = 6;

  typedef struct packed {
    logic                         trig;
    logic [urss_pkg::DIST_W-1:0]  distance;
    logic                         dvalid;
    logic [urss_pkg::SERVO_W-1:0] servo;
  } ranger_result_t;

  typedef struct packed {
    logic                           cfg;
    logic [urss_pkg::REG_IDX_W-1:0] reg_idx;
    logic [31:0]                    value;
    logic                           op;
    logic                           lvl;
    logic [16:0]                    reps;
    logic                           fixed;
    ranger_result_t                 want;
  } stim_row_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [urss_pkg::APB_ADDR_W-1:0] paddr;
  logic [urss_pkg::APB_DATA_W-1:0] pwdata;
  logic [urss_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  urss_evt_if evt_ch ();
  urss_res_if res_ch ();

  ultrasonic_ranger_servo_sweep u_top (
    .clk     (clk),
    .rst     (rst),
    .evt     (evt_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state and configuration
  logic [urss_pkg::PERIOD_W-1:0]   cfg_period;
  logic [urss_pkg::SERVO_W-1:0]    cfg_step;
  logic [urss_pkg::SERVO_W-1:0]    cfg_limit;
  logic [urss_pkg::SERVO_W-1:0]    cfg_restart;
  logic [urss_pkg::PERIOD_W-1:0]   trig_count;
  logic                            trig_level;
  logic                            timing_echo;
  logic [urss_pkg::TICK_WIDTH-1:0] echo_width;
  logic [urss_pkg::DIST_W-1:0]     held_distance;
  logic [urss_pkg::SERVO_W-1:0]    servo_pos;

  ranger_result_t results_due[$];
  stim_row_t rows[$];
  bit steady;
  int mismatches;
  int n_events;
  int n_checked;
  int n_distances;
  int n_writes;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  function automatic logic [urss_pkg::DIST_W-1:0] echo_to_distance(
    input logic [urss_pkg::TICK_WIDTH-1:0] t);
    logic [63:0] w;
    logic [63:0] q;
    w = 64'(t);
    q = (64'd256 * (w * w + 64'd16700 * w + 64'd86490) + 64'd50000) / 64'd100000;
    if (q > 64'hFF_FFFF) q = 64'hFF_FFFF;
    return q[urss_pkg::DIST_W-1:0];
  endfunction

  function automatic ranger_result_t step_ranger(input logic op, input logic lvl);
    ranger_result_t r;
    logic [urss_pkg::SERVO_W:0] sum;
    r.dvalid = 1'b0;
    if (op == EV_TICK) begin
      if (timing_echo) begin
        if (echo_width != '1) echo_width = echo_width + 1'b1;
      end else begin
        if (trig_count == '0) trig_level = 1'b0;
        trig_count = trig_count + 1'b1;
        if (trig_count == cfg_period) begin
          trig_level = 1'b1;
          trig_count = '0;
        end
      end
    end else if (lvl == LVL_RISE) begin
      echo_width = '0;
      timing_echo = 1'b1;
    end else begin
      timing_echo = 1'b0;
      held_distance = echo_to_distance(echo_width);
      sum = {1'b0, servo_pos} + {1'b0, cfg_step};
      servo_pos = (sum > {1'b0, cfg_limit}) ? cfg_restart : sum[urss_pkg::SERVO_W-1:0];
      r.dvalid = 1'b1;
    end
    r.trig = trig_level;
    r.distance = held_distance;
    r.servo = servo_pos;
    return r;
  endfunction

  task automatic send_event(input logic op, input logic lvl, input logic fixed,
                            input ranger_result_t want);
    int gap;
    ranger_result_t pred;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      evt_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    evt_ch.valid <= 1'b1;
    evt_ch.op <= op;
    evt_ch.echo_level <= lvl;
    @(posedge clk);
    while (!evt_ch.ready) @(posedge clk);
    pred = step_ranger(op, lvl);
    results_due.push_back(fixed ? want : pred);
    n_events++;
  endtask

  task automatic settle();
    evt_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [urss_pkg::REG_IDX_W-1:0] idx, input logic [31:0] value);
    logic [31:0] held;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      urss_pkg::REG_TRIGGER_PERIOD: begin
        cfg_period = value[urss_pkg::PERIOD_W-1:0];
        held = 32'(cfg_period);
      end
      urss_pkg::REG_SERVO_STEP: begin
        cfg_step = value[urss_pkg::SERVO_W-1:0];
        held = 32'(cfg_step);
      end
      urss_pkg::REG_SERVO_LIMIT: begin
        cfg_limit = value[urss_pkg::SERVO_W-1:0];
        held = 32'(cfg_limit);
      end
      default: begin
        cfg_restart = value[urss_pkg::SERVO_W-1:0];
        held = 32'(cfg_restart);
      end
    endcase
    // read back
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== held)
      report_mismatch($sformatf("register %0d read %0h, wrote %0h", idx, prdata, held));
    psel <= 1'b0;
    penable <= 1'b0;
    n_writes++;
  endtask

  function automatic void add_event(input logic op, input logic lvl, input int reps);
    stim_row_t r;
    r = '0;
    r.op = op;
    r.lvl = lvl;
    r.reps = 17'(reps);
    rows.push_back(r);
  endfunction

  function automatic void add_known(input logic op, input logic lvl, input logic trig,
                                    input logic [urss_pkg::DIST_W-1:0] distance,
                                    input logic dvalid,
                                    input logic [urss_pkg::SERVO_W-1:0] servo);
    stim_row_t r;
    r = '0;
    r.op = op;
    r.lvl = lvl;
    r.reps = 17'd1;
    r.fixed = 1'b1;
    r.want.trig = trig;
    r.want.distance = distance;
    r.want.dvalid = dvalid;
    r.want.servo = servo;
    rows.push_back(r);
  endfunction

  function automatic void add_write(input logic [urss_pkg::REG_IDX_W-1:0] idx,
                                    input logic [31:0] value);
    stim_row_t r;
    r = '0;
    r.cfg = 1'b1;
    r.reg_idx = idx;
    r.value = value;
    rows.push_back(r);
  endfunction

  always @(posedge clk) begin
    if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 idle_cycles, results_due.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : result_checker
    int stall;
    ranger_result_t want;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      if (results_due.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = results_due.pop_front();
        n_checked++;
        if (want.dvalid) n_distances++;
        if (res_ch.trigger_out !== want.trig)
          report_mismatch($sformatf("trigger_out %b, want %b", res_ch.trigger_out, want.trig));
        if (res_ch.distance_fixed !== want.distance)
          report_mismatch($sformatf("distance_fixed %0d, want %0d",
                                    res_ch.distance_fixed, want.distance));
        if (res_ch.distance_valid !== want.dvalid)
          report_mismatch($sformatf("distance_valid %b, want %b",
                                    res_ch.distance_valid, want.dvalid));
        if (res_ch.servo_width !== want.servo)
          report_mismatch($sformatf("servo_width %0d, want %0d", res_ch.servo_width, want.servo));
      end
    end
  end

  initial begin : stimulus
    int ph;
    int phase_end;
    int kind;
    int n;
    int pick;
    logic [31:0] v;
    rst <= 1'b1;
    evt_ch.valid <= 1'b0;
    evt_ch.op <= EV_TICK;
    evt_ch.echo_level <= LVL_FALL;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    steady = 1'b0;
    cfg_period = urss_pkg::TRIGGER_PERIOD_RST;
    cfg_step = urss_pkg::SERVO_STEP_RST;
    cfg_limit = urss_pkg::SERVO_LIMIT_RST;
    cfg_restart = urss_pkg::SERVO_RESTART_RST;
    trig_count = '0;
    trig_level = 1'b0;
    timing_echo = 1'b0;
    echo_width = '0;
    held_distance = '0;
    servo_pos = urss_pkg::SERVO_POS_RST;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    add_known(EV_TICK, LVL_FALL, 1'b0, 24'd0, 1'b0, 12'd405);
    add_known(EV_EDGE, LVL_FALL, 1'b0, 24'd221, 1'b1, 12'd510);
    add_known(EV_EDGE, LVL_RISE, 1'b0, 24'd221, 1'b0, 12'd510);
    add_event(EV_TICK, LVL_RISE, 5);
    add_event(EV_EDGE, LVL_FALL, 1);
    add_event(EV_EDGE, LVL_RISE, 2);
    add_event(EV_TICK, LVL_FALL, 3);
    add_event(EV_EDGE, LVL_FALL, 1);
    add_event(EV_TICK, LVL_RISE, 3);
    add_write(urss_pkg::REG_SERVO_STEP, 32'd4095);
    add_write(urss_pkg::REG_SERVO_LIMIT, 32'd4095);
    add_write(urss_pkg::REG_SERVO_RESTART, 32'd0);
    add_event(EV_EDGE, LVL_FALL, 3);
    add_write(urss_pkg::REG_SERVO_STEP, 32'd0);
    add_write(urss_pkg::REG_SERVO_LIMIT, 32'd0);
    add_event(EV_EDGE, LVL_FALL, 2);
    add_write(urss_pkg::REG_SERVO_STEP, 32'd1);
    add_write(urss_pkg::REG_SERVO_RESTART, 32'd4095);
    add_event(EV_EDGE, LVL_FALL, 2);
    // period of one holds the trigger high
    add_write(urss_pkg::REG_TRIGGER_PERIOD, 32'd1);
    add_event(EV_TICK, LVL_FALL, 4);
    add_write(urss_pkg::REG_TRIGGER_PERIOD, 32'd3);
    add_event(EV_TICK, LVL_FALL, 7);
    add_write(urss_pkg::REG_TRIGGER_PERIOD, 32'(urss_pkg::TRIGGER_PERIOD_RST));
    add_event(EV_TICK, LVL_FALL, 100);
    // period of zero: no pulse within a short run
    add_write(urss_pkg::REG_TRIGGER_PERIOD, 32'd0);
    add_event(EV_TICK, LVL_FALL, 20);
    add_write(urss_pkg::REG_TRIGGER_PERIOD, 32'd65535);
    add_event(EV_TICK, LVL_RISE, 4);
    // long echo
    add_event(EV_EDGE, LVL_RISE, 1);
    add_event(EV_TICK, LVL_FALL, 300);
    add_event(EV_EDGE, LVL_FALL, 1);

    foreach (rows[i]) begin
      if (rows[i].cfg) begin
        settle();
        write_reg(rows[i].reg_idx, rows[i].value);
      end else begin
        steady = (rows[i].reps > 50);
        repeat (rows[i].reps) send_event(rows[i].op, rows[i].lvl, rows[i].fixed, '0);
        if (rows[i].fixed) begin
          // typed-in expectation replaces the predicted one
          void'(results_due.pop_back());
          results_due.push_back(rows[i].want);
        end
      end
    end
    steady = 1'b0;

    // random part
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      if (ph == 0) v = 32'd1;
      else if (ph == 1) v = 32'd65535;
      else if ($urandom_range(0, 4) == 0) v = 32'd0;
      else v = $urandom_range(2, 60);
      write_reg(urss_pkg::REG_TRIGGER_PERIOD, v);
      pick = $urandom_range(0, 3);
      v = (pick == 0) ? 32'd0 : (pick == 1) ? 32'd4095 : $urandom_range(0, 600);
      write_reg(urss_pkg::REG_SERVO_STEP, v);
      pick = $urandom_range(0, 3);
      v = (pick == 0) ? 32'd0 : (pick == 1) ? 32'd4095 : $urandom_range(0, 4095);
      write_reg(urss_pkg::REG_SERVO_LIMIT, v);
      pick = $urandom_range(0, 3);
      v = (pick == 0) ? 32'd0 : (pick == 1) ? 32'd4095 : $urandom_range(0, 4095);
      write_reg(urss_pkg::REG_SERVO_RESTART, v);
      phase_end = n_events + PHASE_ITEMS;
      while (n_events < phase_end) begin
        steady = ($urandom_range(0, 5) == 0);
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          n = $urandom_range(0, 12);
          repeat (n) send_event(EV_TICK, 1'($urandom_range(0, 1)), 1'b0, '0);
          send_event(EV_EDGE, LVL_RISE, 1'b0, '0);
          n = ($urandom_range(0, 24) == 0) ? $urandom_range(100, 400) : $urandom_range(0, 20);
          repeat (n) send_event(EV_TICK, 1'($urandom_range(0, 1)), 1'b0, '0);
          send_event(EV_EDGE, LVL_FALL, 1'b0, '0);
        end else begin
          n = $urandom_range(1, 6);
          repeat (n) send_event(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
        end
      end
    end
    steady = 1'b0;

    settle();
    repeat (36) @(posedge clk);
    $display("covered %0d events, %0d results checked, %0d of them distances", n_events,
             n_checked, n_distances);
    $display("%0d register writes read back, %0d random settings, %0d mismatches", n_writes,
             RANDOM_PHASES, mismatches);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
